@@ rtl/kms_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the key matrix debounce scanner.
// Used by every module of the block; depends on nothing.
package kms_pkg;

  localparam int MAX_ROWS = 8;
  localparam int MAX_COLS = 8;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int KEYS     = MAX_ROWS * MAX_COLS;
  localparam int KEY_AW   = ROW_W + COL_W;
  localparam int CNT_W    = 8;
  localparam int LINE_W   = 3;
  localparam int SENSE_W  = 8;
  localparam int DIM_W    = 4;

  localparam int EVQ_DEPTH     = 16;
  localparam int EVQ_AW        = $clog2(EVQ_DEPTH);
  localparam int EVQ_PUSH_MAX  = 3;
  localparam int EVQ_ISSUE_MAX = EVQ_DEPTH - 2 * EVQ_PUSH_MAX;

  localparam logic [2:0] REG_ENABLED         = 3'd0;
  localparam logic [2:0] REG_ROWS_ARE_INPUTS = 3'd1;
  localparam logic [2:0] REG_ROWS_IN_USE     = 3'd2;
  localparam logic [2:0] REG_COLS_IN_USE     = 3'd3;
  localparam logic [2:0] REG_DEBOUNCE        = 3'd4;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_HELD    = 2'd1,
    EV_RELEASE = 2'd2
  } ev_kind_t;

  typedef struct packed {
    logic                 enabled;
    logic                 rows_are_inputs;
    logic [DIM_W-1:0]     rows_in_use;
    logic [DIM_W-1:0]     cols_in_use;
    logic [CNT_W-1:0]     debounce_samples;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             pressed;
  } key_state_t;

  typedef struct packed {
    logic              rd_en;
    logic [KEY_AW-1:0] rd_addr;
    logic              wr_en;
    logic [KEY_AW-1:0] wr_addr;
    key_state_t        wr_data;
  } ram_req_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    ev_kind_t         kind;
    logic             last;
  } event_t;

  typedef struct packed {
    logic [1:0]   n;
    event_t [2:0] ev;
  } push_t;

endpackage

@@ rtl/kms_key_ram.sv @@
`timescale 1ns / 1ps
// Per-key state memory: debounce count and pressed flag, one entry per key.
// Synchronous read; per-entry valid bits make entries not written since reset read as zero.
module kms_key_ram (
  input  logic                clk,
  input  logic                rst_n,
  input  kms_pkg::ram_req_t   req,
  output kms_pkg::key_state_t rd_data
);
  import kms_pkg::*;

  key_state_t      mem_r [KEYS];
  logic [KEYS-1:0] vld_r;
  key_state_t      rd_data_r;
  logic            rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

@@ rtl/kms_scan.sv @@
`timescale 1ns / 1ps
// Strobe sequencer and debounce update: walks the sensed keys of one request,
// read-modify-writes the key RAM and forms the event stream. Depends on kms_pkg.
module kms_scan (
  input  logic                         clk,
  input  logic                         rst_n,
  input  kms_pkg::cfg_t                cfg,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [kms_pkg::LINE_W-1:0]   in_strobe_line,
  input  logic [kms_pkg::SENSE_W-1:0]  in_sense_levels,
  input  logic [kms_pkg::EVQ_AW:0]     evq_count,
  output kms_pkg::ram_req_t            ram_req,
  input  kms_pkg::key_state_t          ram_rd_data,
  output kms_pkg::push_t               push
);
  import kms_pkg::*;

  logic [DIM_W-1:0] rows_c, cols_c, drive_n, sense_n;
  logic             strobe_ok, in_acc, issue, a_done;

  logic               a_valid_r, a_valid_nxt;
  logic [LINE_W-1:0]  a_line_r, a_line_nxt;
  logic [SENSE_W-1:0] a_sense_r, a_sense_nxt;
  logic [2:0]         a_idx_r, a_idx_nxt;
  logic [2:0]         a_last_r, a_last_nxt;

  logic [ROW_W-1:0] i_row;
  logic [COL_W-1:0] i_col;

  logic             b_valid_r, b_end_r, b_closed_r;
  logic [ROW_W-1:0] b_row_r;
  logic [COL_W-1:0] b_col_r;
  logic [KEY_AW-1:0] b_addr;

  logic              fw_valid_r;
  logic [KEY_AW-1:0] fw_addr_r;
  key_state_t        fw_data_r;

  key_state_t       cur, upd;
  logic [CNT_W-1:0] thresh;
  logic             e_press, e_held, e_rel;

  event_t     nev0, nev1;
  logic [1:0] nw, ln, lidx;
  event_t     lst [3];

  logic   p_valid_r, p_valid_nxt;
  event_t p_ev_r, p_ev_nxt;

  assign rows_c    = (cfg.rows_in_use > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : cfg.rows_in_use;
  assign cols_c    = (cfg.cols_in_use > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cfg.cols_in_use;
  assign drive_n   = cfg.rows_are_inputs ? cols_c : rows_c;
  assign sense_n   = cfg.rows_are_inputs ? rows_c : cols_c;
  assign strobe_ok = cfg.enabled && ({1'b0, in_strobe_line} < drive_n) && (sense_n != '0);

  assign issue    = a_valid_r && (evq_count <= (EVQ_AW + 1)'(EVQ_ISSUE_MAX));
  assign a_done   = issue && (a_idx_r == a_last_r);
  assign in_stall = a_valid_r && !a_done;
  assign in_acc   = in_valid && !in_stall;

  assign i_row = cfg.rows_are_inputs ? ROW_W'(a_idx_r) : ROW_W'(a_line_r);
  assign i_col = cfg.rows_are_inputs ? COL_W'(a_line_r) : COL_W'(a_idx_r);

  always_comb begin
    a_valid_nxt = a_valid_r;
    a_line_nxt  = a_line_r;
    a_sense_nxt = a_sense_r;
    a_idx_nxt   = a_idx_r;
    a_last_nxt  = a_last_r;
    if (issue) begin
      a_idx_nxt = a_idx_r + 3'd1;
      if (a_done) begin
        a_valid_nxt = 1'b0;
      end
    end
    if (in_acc && strobe_ok) begin
      a_valid_nxt = 1'b1;
      a_line_nxt  = in_strobe_line;
      a_sense_nxt = in_sense_levels;
      a_idx_nxt   = 3'd0;
      a_last_nxt  = 3'(sense_n - DIM_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r  <= 1'b0;
      b_valid_r  <= 1'b0;
      fw_valid_r <= 1'b0;
      p_valid_r  <= 1'b0;
    end else begin
      a_valid_r  <= a_valid_nxt;
      b_valid_r  <= issue;
      fw_valid_r <= b_valid_r;
      p_valid_r  <= p_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_line_r   <= a_line_nxt;
    a_sense_r  <= a_sense_nxt;
    a_idx_r    <= a_idx_nxt;
    a_last_r   <= a_last_nxt;
    b_row_r    <= i_row;
    b_col_r    <= i_col;
    b_closed_r <= !a_sense_r[a_idx_r];
    b_end_r    <= a_done;
    fw_addr_r  <= b_addr;
    fw_data_r  <= upd;
    p_ev_r     <= p_ev_nxt;
  end

  assign b_addr = {b_row_r, b_col_r};

  always_comb begin
    cur     = (fw_valid_r && (fw_addr_r == b_addr)) ? fw_data_r : ram_rd_data;
    thresh  = cfg.debounce_samples >> 1;
    upd     = cur;
    e_press = 1'b0;
    e_held  = 1'b0;
    e_rel   = 1'b0;
    if (b_closed_r) begin
      if (cur.cnt < cfg.debounce_samples) begin
        upd.cnt = cur.cnt + CNT_W'(1);
      end
      if (upd.cnt >= thresh) begin
        e_press     = !cur.pressed;
        e_held      = 1'b1;
        upd.pressed = 1'b1;
      end
    end else begin
      if (cur.cnt != '0) begin
        upd.cnt = cur.cnt - CNT_W'(1);
      end
      if (upd.cnt < thresh) begin
        e_rel       = cur.pressed;
        upd.pressed = 1'b0;
      end
    end
  end

  assign ram_req.rd_en   = issue;
  assign ram_req.rd_addr = {i_row, i_col};
  assign ram_req.wr_en   = b_valid_r;
  assign ram_req.wr_addr = b_addr;
  assign ram_req.wr_data = upd;

  always_comb begin
    nev0 = '{row: b_row_r, col: b_col_r, kind: EV_HELD, last: 1'b0};
    nev1 = '{row: b_row_r, col: b_col_r, kind: EV_HELD, last: 1'b0};
    nw   = 2'd0;
    if (b_valid_r) begin
      if (e_press) begin
        nev0.kind = EV_PRESS;
        nw        = 2'd2;
      end else if (e_held) begin
        nw = 2'd1;
      end else if (e_rel) begin
        nev0.kind = EV_RELEASE;
        nw        = 2'd1;
      end
    end
    lst[0] = p_valid_r ? p_ev_r : nev0;
    lst[1] = p_valid_r ? nev0 : nev1;
    lst[2] = nev1;
    ln     = nw + {1'b0, p_valid_r};
    lidx   = ln - 2'd1;

    p_valid_nxt = p_valid_r;
    p_ev_nxt    = p_ev_r;
    push.n      = 2'd0;
    if (b_valid_r && b_end_r) begin
      push.n      = ln;
      p_valid_nxt = 1'b0;
      for (int j = 0; j < 3; j++) begin
        lst[j].last = (ln != 2'd0) && (2'(j) == lidx);
      end
    end else if (ln != 2'd0) begin
      push.n      = lidx;
      p_valid_nxt = 1'b1;
      p_ev_nxt    = lst[lidx];
    end
    push.ev[0] = lst[0];
    push.ev[1] = lst[1];
    push.ev[2] = lst[2];
  end

endmodule

@@ rtl/kms_evq.sv @@
`timescale 1ns / 1ps
// Event queue: takes up to three events a cycle, delivers one a cycle unless the output stalls.
// Depends on kms_pkg.
module kms_evq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  kms_pkg::push_t            push,
  output logic [kms_pkg::EVQ_AW:0]  count,
  output logic                      out_valid,
  input  logic                      out_stall,
  output kms_pkg::event_t           out_ev
);
  import kms_pkg::*;

  event_t              q_r [EVQ_DEPTH];
  logic [EVQ_AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [EVQ_AW:0]     cnt_r, cnt_nxt;
  logic                pop;

  assign pop     = (cnt_r != '0) && !out_stall;
  assign wp_nxt  = wp_r + EVQ_AW'(push.n);
  assign rp_nxt  = rp_r + EVQ_AW'(pop);
  assign cnt_nxt = cnt_r + (EVQ_AW + 1)'(push.n) - (EVQ_AW + 1)'(pop);

  always_ff @(posedge clk) begin
    for (int j = 0; j < EVQ_PUSH_MAX; j++) begin
      if (2'(j) < push.n) begin
        q_r[wp_r + EVQ_AW'(j)] <= push.ev[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign count     = cnt_r;
  assign out_valid = (cnt_r != '0);
  assign out_ev    = q_r[rp_r];

endmodule

@@ rtl/key_matrix_debounce_scanner_top.sv @@
`timescale 1ns / 1ps
// Key matrix debounce scanner, top level: configuration registers and wiring.
// Depends on kms_pkg, kms_key_ram, kms_scan and kms_evq.
//
// Each request is one strobe: the driven line index and the active-low sense levels.
// The scanner visits one sensed key per cycle while the queue has room, reading its
// debounce count and pressed flag from a 64-entry key RAM and writing the update back
// the next cycle (a one-entry bypass covers back-to-back visits to the same key). A
// strobe occupies the sequencer until every sense line in use (1 to 8) has been
// visited; the next strobe is taken in the cycle the last key is issued. Events leave
// one per cycle, unless the output stalls, from a 16-entry queue; the sequencer
// pauses when the queue nears full. A press is not held back; every other event is
// held back until the next event of the strobe or its last key settles the last-event
// flag, so the final events of a strobe enter the queue once its last key has been
// processed.
// The key RAM is usable straight out of reset; no clearing pass.
module key_matrix_debounce_scanner_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [kms_pkg::LINE_W-1:0]    in_strobe_line,
  input  logic [kms_pkg::SENSE_W-1:0]   in_sense_levels,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kms_pkg::ROW_W-1:0]     out_key_row,
  output logic [kms_pkg::COL_W-1:0]     out_key_col,
  output logic [1:0]                    out_event_kind,
  output logic                          out_last_event,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [7:0]                    cfg_wdata
);
  import kms_pkg::*;

  cfg_t                cfg_r, cfg_nxt;
  ram_req_t            ram_req;
  key_state_t          ram_rd_data;
  push_t               push;
  logic [EVQ_AW:0]     evq_count;
  event_t              out_ev;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLED:         cfg_nxt.enabled          = cfg_wdata[0];
        REG_ROWS_ARE_INPUTS: cfg_nxt.rows_are_inputs  = cfg_wdata[0];
        REG_ROWS_IN_USE:     cfg_nxt.rows_in_use      = cfg_wdata[DIM_W-1:0];
        REG_COLS_IN_USE:     cfg_nxt.cols_in_use      = cfg_wdata[DIM_W-1:0];
        REG_DEBOUNCE:        cfg_nxt.debounce_samples = cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled          <= 1'b1;
      cfg_r.rows_are_inputs  <= 1'b1;
      cfg_r.rows_in_use      <= DIM_W'(MAX_ROWS);
      cfg_r.cols_in_use      <= DIM_W'(MAX_COLS);
      cfg_r.debounce_samples <= CNT_W'(10);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  kms_key_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  kms_scan u_scan (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_strobe_line  (in_strobe_line),
    .in_sense_levels (in_sense_levels),
    .evq_count       (evq_count),
    .ram_req         (ram_req),
    .ram_rd_data     (ram_rd_data),
    .push            (push)
  );

  kms_evq u_evq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .count     (evq_count),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_ev    (out_ev)
  );

  assign out_key_row    = out_ev.row;
  assign out_key_col    = out_ev.col;
  assign out_event_kind = out_ev.kind;
  assign out_last_event = out_ev.last;

endmodule

@@ rtl/kms_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the key matrix debounce scanner, bound to the top level.
// Depends on kms_pkg.
module kms_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [kms_pkg::LINE_W-1:0]  in_strobe_line,
  input logic [kms_pkg::SENSE_W-1:0] in_sense_levels,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [kms_pkg::ROW_W-1:0]   out_key_row,
  input logic [kms_pkg::COL_W-1:0]   out_key_col,
  input logic [1:0]                  out_event_kind,
  input logic                        out_last_event,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic [2:0]                  cfg_index,
  input logic [7:0]                  cfg_wdata
);
  import kms_pkg::*;

  logic             out_acc;
  logic             pend_r;
  logic [ROW_W-1:0] pend_row_r;
  logic [COL_W-1:0] pend_col_r;

  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (out_acc) begin
      pend_r <= (out_event_kind == EV_PRESS);
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      pend_row_r <= out_key_row;
      pend_col_r <= out_key_col;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("event queue not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_key_row) && $stable(out_key_col)
      && $stable(out_event_kind) && $stable(out_last_event))
    else $error("stalled event changed");

  a_press_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EV_PRESS) |-> !out_last_event)
    else $error("press closed a strobe");

  a_press_then_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && pend_r |-> (out_event_kind == EV_HELD) && (out_key_row == pend_row_r)
      && (out_key_col == pend_col_r))
    else $error("press not followed by held of the same key");

endmodule

bind key_matrix_debounce_scanner_top kms_checker u_kms_checker (.*);

@@ test/tb_key_matrix_debounce_scanner_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for key_matrix_debounce_scanner_top: directed and random strobes,
// a built-in debounce predictor, and an in-order check of every key event.
// Depends on kms_pkg and the scanner RTL only.
module tb_key_matrix_debounce_scanner_top;
  import kms_pkg::*;

  localparam int          CYCLE_LIMIT = 300000;
  localparam int          LONG_HOLD   = 400;
  localparam int          SETTLE      = 40;
  localparam logic [2:0]  REG_UNUSED  = 3'd7;

  typedef struct {
    logic [LINE_W-1:0]  line;
    logic [SENSE_W-1:0] sense;
  } strobe_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [LINE_W-1:0]   in_strobe_line = '0;
  logic [SENSE_W-1:0]  in_sense_levels = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ROW_W-1:0]    out_key_row;
  logic [COL_W-1:0]    out_key_col;
  logic [1:0]          out_event_kind;
  logic                out_last_event;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [2:0]          cfg_index = '0;
  logic [7:0]          cfg_wdata = '0;

  // expected state of the block
  logic [CNT_W-1:0] key_cnt [KEYS];
  logic             key_prs [KEYS];
  logic             m_enabled = 1'b1;
  logic             m_rows_are_inputs = 1'b1;
  logic [DIM_W-1:0] m_rows = 4'd8;
  logic [DIM_W-1:0] m_cols = 4'd8;
  logic [CNT_W-1:0] m_samples = 8'd10;

  strobe_t strobe_queue [$];
  event_t  pending_events [$];

  int unsigned cycles = 0;
  int          errors = 0;
  int          n_strobes = 0;
  int          n_events = 0;
  int          n_writes = 0;
  int          in_gap = 0;
  int          rx_gap = 0;
  int          hold_left = 0;
  bit          in_idling = 1'b1;
  bit          out_idling = 1'b1;
  logic        hold_toggle = 1'b0;
  logic        hold_seen = 1'b0;
  logic [7:0]  line_pat [8];

  key_matrix_debounce_scanner_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_strobe_line  (in_strobe_line),
    .in_sense_levels (in_sense_levels),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_key_row     (out_key_row),
    .out_key_col     (out_key_col),
    .out_event_kind  (out_event_kind),
    .out_last_event  (out_last_event),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic int dim_clamp(input logic [DIM_W-1:0] v);
    return (v > 8) ? 8 : int'(v);
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 20) $display("MISMATCH cycle %0d: %s", cycles, msg);
  endtask

  task automatic debounce_strobe(input logic [LINE_W-1:0] line, input logic [SENSE_W-1:0] sense);
    int          drive_n;
    int          sense_n;
    int          thresh;
    int          cnt;
    int          idx;
    logic [2:0]  r;
    logic [2:0]  c;
    event_t      ev;
    event_t      evs [$];
    if (!m_enabled) return;
    drive_n = m_rows_are_inputs ? dim_clamp(m_cols) : dim_clamp(m_rows);
    sense_n = m_rows_are_inputs ? dim_clamp(m_rows) : dim_clamp(m_cols);
    if (line >= drive_n) return;
    thresh = m_samples / 2;
    for (int i = 0; i < sense_n; i++) begin
      r = m_rows_are_inputs ? 3'(i) : line;
      c = m_rows_are_inputs ? line : 3'(i);
      idx = r * MAX_COLS + c;
      cnt = key_cnt[idx];
      ev.row = r;
      ev.col = c;
      ev.last = 1'b0;
      if (!sense[i]) begin
        if (cnt < m_samples) cnt++;
        key_cnt[idx] = 8'(cnt);
        if (cnt >= thresh) begin
          if (!key_prs[idx]) begin
            ev.kind = EV_PRESS;
            evs.push_back(ev);
          end
          key_prs[idx] = 1'b1;
          ev.kind = EV_HELD;
          evs.push_back(ev);
        end
      end else begin
        if (cnt > 0) cnt--;
        key_cnt[idx] = 8'(cnt);
        if (cnt < thresh) begin
          if (key_prs[idx]) begin
            ev.kind = EV_RELEASE;
            evs.push_back(ev);
          end
          key_prs[idx] = 1'b0;
        end
      end
    end
    foreach (evs[k]) begin
      ev = evs[k];
      ev.last = (k == evs.size() - 1);
      pending_events.push_back(ev);
    end
  endtask

  // driver
  always @(posedge clk) begin
    strobe_t s;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        debounce_strobe(in_strobe_line, in_sense_levels);
        n_strobes++;
      end
      if (in_valid && in_stall) begin
        // hold
      end else if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (strobe_queue.size() != 0) begin
        s = strobe_queue.pop_front();
        in_valid <= 1'b1;
        in_strobe_line <= s.line;
        in_sense_levels <= s.sense;
        in_gap <= in_idling ? $urandom_range(0, 9) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else if (hold_seen != hold_toggle) begin
      hold_left <= LONG_HOLD;
      hold_seen <= hold_toggle;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    event_t want;
    int     nxt;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_events++;
        if (pending_events.size() == 0) begin
          report_mismatch($sformatf("unexpected event row %0d col %0d kind %0d last %0d",
                                    out_key_row, out_key_col, out_event_kind, out_last_event));
        end else begin
          want = pending_events.pop_front();
          if (out_key_row !== want.row || out_key_col !== want.col ||
              out_event_kind !== want.kind || out_last_event !== want.last)
            report_mismatch($sformatf("got row %0d col %0d kind %0d last %0d, want %0d %0d %0d %0d",
                                      out_key_row, out_key_col, out_event_kind, out_last_event,
                                      want.row, want.col, want.kind, want.last));
        end
        nxt = out_idling ? $urandom_range(0, 9) : 0;
      end else begin
        nxt = (rx_gap > 0) ? rx_gap - 1 : 0;
      end
      rx_gap <= nxt;
      out_stall <= (nxt != 0) || (hold_left != 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d events outstanding", cycles, pending_events.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_strobe(input logic [LINE_W-1:0] line, input logic [SENSE_W-1:0] sense);
    strobe_t s;
    s.line = line;
    s.sense = sense;
    strobe_queue.push_back(s);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (strobe_queue.size() != 0 || in_valid || pending_events.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_writes++;
    case (idx)
      REG_ENABLED:         m_enabled = data[0];
      REG_ROWS_IN_USE:     m_rows = data[3:0];
      REG_COLS_IN_USE:     m_cols = data[3:0];
      REG_ROWS_ARE_INPUTS: m_rows_are_inputs = data[0];
      REG_DEBOUNCE:        m_samples = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic en, input logic rai, input logic [3:0] rows,
                            input logic [3:0] cols, input logic [7:0] samples);
    drain();
    write_reg(REG_ENABLED, {7'd0, en});
    write_reg(REG_ROWS_ARE_INPUTS, {7'd0, rai});
    write_reg(REG_ROWS_IN_USE, {4'd0, rows});
    write_reg(REG_COLS_IN_USE, {4'd0, cols});
    write_reg(REG_DEBOUNCE, samples);
  endtask

  // scan frames over the driven lines with slowly changing key patterns, bounce and noise
  task automatic queue_scan(input int n_items);
    int         drive_n;
    int         line;
    logic [7:0] s;
    drive_n = m_rows_are_inputs ? dim_clamp(m_cols) : dim_clamp(m_rows);
    line = 0;
    for (int k = 0; k < n_items; k++) begin
      if (drive_n == 0 || $urandom_range(0, 9) == 0) begin
        push_strobe(3'($urandom), 8'($urandom));
      end else begin
        if (line == 0)
          foreach (line_pat[p])
            if ($urandom_range(0, 3) == 0)
              case ($urandom_range(0, 3))
                0:       line_pat[p] = 8'h00;
                1:       line_pat[p] = 8'hFF;
                default: line_pat[p] = 8'(~($urandom & $urandom));
              endcase
        s = line_pat[line];
        if ($urandom_range(0, 7) == 0) s[$urandom_range(0, 7)] = ~s[$urandom_range(0, 7)];
        push_strobe(3'(line), s);
        line = (line + 1) % drive_n;
      end
    end
  endtask

  initial begin
    foreach (key_cnt[k]) begin
      key_cnt[k] = '0;
      key_prs[k] = 1'b0;
    end
    foreach (line_pat[p]) line_pat[p] = 8'hFF;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: full column closes to press, then opens to release
    repeat (5) push_strobe(3'd0, 8'h00);
    push_strobe(3'd0, 8'hFF);
    push_strobe(3'd7, 8'hFE);
    push_strobe(3'd3, 8'hAA);
    push_strobe(3'd5, 8'h55);
    drain();

    // disabled: strobes dropped
    write_reg(REG_ENABLED, 8'h00);
    push_strobe(3'd2, 8'h00);
    push_strobe(3'd2, 8'h00);
    drain();

    // rows driven, three rows, threshold one; a row out of range
    write_reg(REG_ENABLED, 8'h01);
    write_reg(REG_ROWS_ARE_INPUTS, 8'h00);
    write_reg(REG_ROWS_IN_USE, 8'hF3);
    write_reg(REG_DEBOUNCE, 8'd2);
    push_strobe(3'd2, 8'h00);
    push_strobe(3'd3, 8'h00);
    push_strobe(3'd2, 8'hFF);
    drain();

    // tiny sample counts: immediate press, never released
    write_reg(REG_DEBOUNCE, 8'd1);
    push_strobe(3'd0, 8'hFE);
    push_strobe(3'd0, 8'hFF);
    drain();
    write_reg(REG_DEBOUNCE, 8'd0);
    push_strobe(3'd1, 8'h00);
    drain();

    // no sense lines, oversized dimensions, unused register index
    write_reg(REG_ROWS_ARE_INPUTS, 8'h01);
    write_reg(REG_ROWS_IN_USE, 8'h00);
    write_reg(REG_COLS_IN_USE, 8'h1C);
    write_reg(REG_UNUSED, 8'hA5);
    push_strobe(3'd4, 8'h00);
    push_strobe(3'd7, 8'h00);
    drain();
    write_reg(REG_ROWS_IN_USE, 8'h0F);
    write_reg(REG_DEBOUNCE, 8'd255);
    push_strobe(3'd6, 8'h00);

    // random scan phases
    set_config(1'b1, 1'b1, 4'd8, 4'd8, 8'd4);
    queue_scan(40);
    hold_toggle <= ~hold_toggle;

    set_config(1'b1, 1'b0, 4'd5, 4'd7, 8'd6);
    in_idling = 1'b0;
    out_idling = 1'b0;
    queue_scan(30);

    set_config(1'b1, 1'b1, 4'd8, 4'd3, 8'd255);
    in_idling = 1'b1;
    out_idling = 1'b1;
    queue_scan(15);

    set_config(1'b1, 1'b0, 4'd8, 4'd8, 8'd2);
    out_idling = 1'b0;
    queue_scan(40);

    set_config(1'b1, 1'b1, 4'd2, 4'd8, 8'd3);
    in_idling = 1'b0;
    out_idling = 1'b1;
    queue_scan(35);

    drain();
    $display("Ran %0d strobes and checked %0d key events across %0d register writes,",
             n_strobes, n_events, n_writes);
    $display("both scan orientations, sizes 0 to 15, sample counts 0 to 255, long stalls.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
